>>> sv/swtm_pkg.sv
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared types and constants of the sliding-window trimmed mean unit.
// ----------------------------------------------------------------------------
package swtm_pkg;

    // configuration register widths and indexes
    localparam int WL_W   = 7;
    localparam int TRIM_W = 5;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [IDX_W-1:0] CFG_TRIM_COUNT    = 1'b1;

    localparam logic [WL_W-1:0]   WL_RESET   = 7'd64;
    localparam logic [TRIM_W-1:0] TRIM_RESET = 5'd1;

    // result flags in tuser
    localparam int USER_W = 2;

    // per-cycle commands broadcast to every cell of the row
    typedef struct packed {
        logic shift;      // history moves one cell down, new sample in cell 0
        logic load_rank;  // probe takes own sample, rank counter clears
        logic count;      // compare passing probe against own sample
        logic load_keep;  // probe takes own sample tagged with its keep flag
        logic rotate;     // probe ring moves one cell toward cell 0
    } t_cell_ctl;

endpackage

>>> sv/sliding_window_trimmed_mean_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_unit
// Trimmed mean over the most recent samples of a stream.
// ----------------------------------------------------------------------------
// One result per input transaction. The last MAX_WINDOW samples sit in a row
// of cells. Per sample the window is loaded into a probe ring that circulates
// once around the row while each cell counts how many window samples rank
// below its own; the kept samples are then shifted out of cell 0 into an
// accumulator and a serial divider forms the mean. While the window is not
// full or the trim is invalid, the ranking, sum and divide are skipped and the
// result is zero. The next sample is taken only once the result has moved to
// the output register. A new sample is taken while a result waits on the
// output. tuser carries mean_ready (bit 0) and config_error (bit 1).
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_unit #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [SAMPLE_BITS-1:0] sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [SAMPLE_BITS-1:0] trimmed_mean
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
    // [0] mean_ready, [1] config_error
    output logic [swtm_pkg::USER_W-1:0]         m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [swtm_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [swtm_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int OW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (LW > swtm_pkg::WL_W) ? LW : swtm_pkg::WL_W;
    localparam int SW = SAMPLE_BITS + LW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_RANK = 6'b000100,
        S_KEEP = 6'b001000,
        S_SUM  = 6'b010000,
        S_DIV  = 6'b100000
    } t_state;

    // result hand-off state is folded into S_DIV completion and r_res_pend
    t_state r_state, n_state;

    logic [swtm_pkg::WL_W-1:0]   r_window_length;
    logic [swtm_pkg::TRIM_W-1:0] r_trim_count;

    logic [LW-1:0]          r_fill, n_fill;
    logic [CW-1:0]          r_len;
    logic [CW-1:0]          r_lo;
    logic [CW-1:0]          r_hi;
    logic [CW-1:0]          r_keep_n;
    logic                   r_ready;
    logic                   r_err;
    logic [IW-1:0]          r_cnt, n_cnt;
    logic [SW-1:0]          r_sum, n_sum;
    logic                   r_res_pend, n_res_pend;
    logic [SAMPLE_BITS-1:0] r_res_mean, n_res_mean;

    logic                   r_m_valid;
    logic [SAMPLE_BITS-1:0] r_m_mean;
    logic                   r_m_ready;
    logic                   r_m_err;

    swtm_pkg::t_cell_ctl w_ctl;

    logic [CW-1:0]          w_len_eff;
    logic [CW-1:0]          w_trim2;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [SW-1:0]          w_div_quo;
    logic [SW-1:0]          w_sum_add;

    logic [SAMPLE_BITS-1:0] w_hist  [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] w_probe [MAX_WINDOW];
    logic                   w_pv    [MAX_WINDOW];
    logic [IW-1:0]          w_porg  [MAX_WINDOW];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= swtm_pkg::WL_RESET;
            r_trim_count    <= swtm_pkg::TRIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swtm_pkg::CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data;
                swtm_pkg::CFG_TRIM_COUNT:
                    r_trim_count <= i_cfg_data[swtm_pkg::TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_len_eff = (CW'(r_window_length) > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW)
                                                                : CW'(r_window_length);
    assign w_trim2   = CW'({r_trim_count, 1'b0});

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // cell row
    always_comb begin
        w_ctl           = '0;
        w_ctl.shift     = w_in_acc;
        w_ctl.load_rank = (r_state == S_LOAD);
        w_ctl.count     = (r_state == S_RANK);
        w_ctl.load_keep = (r_state == S_KEEP);
        w_ctl.rotate    = (r_state == S_RANK) || (r_state == S_SUM);
    end

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        logic [SAMPLE_BITS-1:0] w_prev;
        if (k == 0) begin : g_head
            assign w_prev = s_axis_tdata[SAMPLE_BITS-1:0];
        end else begin : g_body
            assign w_prev = w_hist[k-1];
        end
        swtm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IW          (IW),
            .CW          (CW),
            .IDX         (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_len       (r_len),
            .i_lo        (r_lo),
            .i_hi        (r_hi),
            .i_hist_prev (w_prev),
            .i_probe_nxt (w_probe[(k + 1) % MAX_WINDOW]),
            .i_pv_nxt    (w_pv[(k + 1) % MAX_WINDOW]),
            .i_porg_nxt  (w_porg[(k + 1) % MAX_WINDOW]),
            .o_hist      (w_hist[k]),
            .o_probe     (w_probe[k]),
            .o_pv        (w_pv[k]),
            .o_porg      (w_porg[k])
        );
    end

    assign w_sum_add = r_sum + (w_pv[0] ? SW'(w_probe[0]) : SW'(0));

    swtm_div #(
        .NW (SW),
        .DW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_sum_add),
        .i_den   (r_keep_n),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_res_pend  = r_res_pend;
        n_res_mean  = r_res_mean;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_fill != LW'(MAX_WINDOW)) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_cnt = '0;
                if (r_ready && !r_err) begin
                    n_state = S_RANK;
                end else begin
                    n_res_pend = 1'b1;
                    n_res_mean = '0;
                    n_state    = S_DIV;
                end
            end
            S_RANK: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IW'(MAX_WINDOW - 1)) begin
                    n_state = S_KEEP;
                end
            end
            S_KEEP: begin
                n_cnt   = '0;
                n_sum   = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum = w_sum_add;
                n_cnt = r_cnt + 1'b1;
                if (CW'(r_cnt) == r_len - 1'b1) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res_pend = 1'b1;
                    n_res_mean = w_div_quo[SAMPLE_BITS-1:0];
                end
                // result waits here until the output register frees up
                if (r_res_pend && w_out_free) begin
                    n_res_pend = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_res_pend <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_res_pend <= n_res_pend;
            if (r_state == S_DIV && r_res_pend && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        r_cnt      <= n_cnt;
        r_sum      <= n_sum;
        r_res_mean <= n_res_mean;
        if (w_in_acc) begin
            r_len    <= w_len_eff;
            r_lo     <= CW'(r_trim_count);
            r_hi     <= w_len_eff - CW'(r_trim_count);
            r_keep_n <= w_len_eff - w_trim2;
            r_ready  <= CW'(n_fill) >= w_len_eff;
            r_err    <= w_trim2 >= w_len_eff;
        end
        if (r_state == S_DIV && r_res_pend && w_out_free) begin
            r_m_mean  <= r_res_mean;
            r_m_ready <= r_ready;
            r_m_err   <= r_err;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OW'(r_m_mean);
    assign m_axis_tuser  = {r_m_err, r_m_ready};

endmodule

>>> sv/swtm_cell.sv
// ----------------------------------------------------------------------------
// swtm_cell
// One cell of the window row: holds one history sample, a travelling probe
// and the rank of its own sample within the current window.
// ----------------------------------------------------------------------------
module swtm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int IW          = 6,
    parameter int CW          = 7,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  swtm_pkg::t_cell_ctl    i_ctl,
    input  logic [CW-1:0]          i_len,
    input  logic [CW-1:0]          i_lo,
    input  logic [CW-1:0]          i_hi,
    input  logic [SAMPLE_BITS-1:0] i_hist_prev,
    input  logic [SAMPLE_BITS-1:0] i_probe_nxt,
    input  logic                   i_pv_nxt,
    input  logic [IW-1:0]          i_porg_nxt,
    output logic [SAMPLE_BITS-1:0] o_hist,
    output logic [SAMPLE_BITS-1:0] o_probe,
    output logic                   o_pv,
    output logic [IW-1:0]          o_porg
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic [SAMPLE_BITS-1:0] r_hist;
    logic [SAMPLE_BITS-1:0] r_probe;
    logic                   r_pv;
    logic [IW-1:0]          r_porg;
    logic [IW-1:0]          r_rank;

    logic w_in_win;
    logic w_keep;
    logic w_hit;

    assign w_in_win = MY_POS < i_len;
    assign w_keep   = w_in_win && (CW'(r_rank) >= i_lo) && (CW'(r_rank) < i_hi);
    // ties are broken by position so every window sample gets a distinct rank
    assign w_hit    = r_pv && ((r_probe < r_hist) ||
                               ((r_probe == r_hist) && (r_porg < MY_IDX)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_hist <= i_hist_prev;
        end
        if (i_ctl.load_rank) begin
            r_probe <= r_hist;
            r_pv    <= w_in_win;
            r_porg  <= MY_IDX;
            r_rank  <= '0;
        end else if (i_ctl.load_keep) begin
            r_probe <= r_hist;
            r_pv    <= w_keep;
        end else if (i_ctl.rotate) begin
            r_probe <= i_probe_nxt;
            r_pv    <= i_pv_nxt;
            r_porg  <= i_porg_nxt;
            if (i_ctl.count && w_hit) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    assign o_hist  = r_hist;
    assign o_probe = r_probe;
    assign o_pv    = r_pv;
    assign o_porg  = r_porg;

endmodule

>>> sv/swtm_div.sv
// ----------------------------------------------------------------------------
// swtm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swtm_div #(
    parameter int NW = 22,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [KW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [DW:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = DW'(w_ge ? (w_trial - {1'b0, r_den}) : w_trial);
            n_quo = {r_quo[NW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == KW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
